// ===== src/rj_pkg.sv =====
// Shared constants and types for the radar Jacobian pipeline.
`timescale 1ns / 1ps
package rj_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int NUM_DIV = 6;
  localparam int DIV_RPX = 0;
  localparam int DIV_RPY = 1;
  localparam int DIV_BPX = 2;
  localparam int DIV_BPY = 3;
  localparam int DIV_TPX = 4;
  localparam int DIV_TPY = 5;

  typedef struct packed {
    logic                zero;
    logic [NUM_DIV-1:0] neg;
  } rj_side_t;

endpackage

// ===== src/radar_jacobian.sv =====
// Radar measurement Jacobian: top level with input stages, root and divider rows.
//
// Takes one track state (pos_x, pos_y, vel_x, vel_y) per transaction and returns the
// eight non-constant Jacobian entries, rounded and saturated to the word range, plus
// zero_position when both positions are zero (entries then zero). A new transaction
// is accepted every cycle while no finished result is stalled. The path runs through
// three input stages, a row of WORD_WIDTH+FRAC_BITS square-root cells (one root bit
// each), a two-stage multiplier, and WORD_WIDTH+1 divider cells (one quotient bit
// each) between an overflow check and a rounding stage, then the output register.
// The whole pipeline holds while a finished result is stalled; in_stall then follows.
`timescale 1ns / 1ps
module radar_jacobian #(
  parameter int WORD_WIDTH = rj_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = rj_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [WORD_WIDTH-1:0] in_pos_x,
  input  logic signed [WORD_WIDTH-1:0] in_pos_y,
  input  logic signed [WORD_WIDTH-1:0] in_vel_x,
  input  logic signed [WORD_WIDTH-1:0] in_vel_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [WORD_WIDTH-1:0] out_range_by_px,
  output logic signed [WORD_WIDTH-1:0] out_range_by_py,
  output logic signed [WORD_WIDTH-1:0] out_bearing_by_px,
  output logic signed [WORD_WIDTH-1:0] out_bearing_by_py,
  output logic signed [WORD_WIDTH-1:0] out_rate_by_px,
  output logic signed [WORD_WIDTH-1:0] out_rate_by_py,
  output logic signed [WORD_WIDTH-1:0] out_rate_by_vx,
  output logic signed [WORD_WIDTH-1:0] out_rate_by_vy,
  output logic                         out_zero_position
);

  localparam int W    = WORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int SW   = 2 * W;
  localparam int NR   = W + F;
  localparam int K    = W + 1;
  localparam int NW_R = W + 2 * F;
  localparam int NW_T = W + SW + 2 * F;
  localparam int DW_T = SW + NR;
  localparam int LAT  = NR + K + 8;

  localparam int PM_LO = 0;
  localparam int QM_LO = W;
  localparam int S_LO  = 2 * W;
  localparam int T_LO  = 2 * W + SW;
  localparam int PN_B  = 2 * W + 2 * SW;
  localparam int QN_B  = PN_B + 1;
  localparam int TN_B  = PN_B + 2;
  localparam int ZR_B  = PN_B + 3;
  localparam int PW    = PN_B + 4;

  localparam logic [K:0] HALF = (K+1)'(1) << (W - 1);
  localparam logic [K:0] MAXP = HALF - (K+1)'(1);

  logic           en;
  logic [LAT-1:0] vld_r;

  assign en       = !vld_r[LAT-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // stage A: magnitudes and products
  logic [W-1:0]         pm;
  logic [W-1:0]         qm;
  logic [W-1:0]         a_pm_r;
  logic [W-1:0]         a_qm_r;
  logic                 a_pn_r;
  logic                 a_qn_r;
  logic                 a_zero_r;
  logic [SW-1:0]        a_pp_r;
  logic [SW-1:0]        a_qq_r;
  logic signed [SW-1:0] a_xq_r;
  logic signed [SW-1:0] a_yp_r;

  assign pm = in_pos_x[W-1] ? W'(-in_pos_x) : W'(in_pos_x);
  assign qm = in_pos_y[W-1] ? W'(-in_pos_y) : W'(in_pos_y);

  always_ff @(posedge clk) begin
    if (en) begin
      a_pm_r   <= pm;
      a_qm_r   <= qm;
      a_pn_r   <= in_pos_x[W-1];
      a_qn_r   <= in_pos_y[W-1];
      a_zero_r <= (in_pos_x == '0) && (in_pos_y == '0);
      a_pp_r   <= SW'(pm) * SW'(pm);
      a_qq_r   <= SW'(qm) * SW'(qm);
      a_xq_r   <= SW'(in_vel_x) * SW'(in_pos_y);
      a_yp_r   <= SW'(in_vel_y) * SW'(in_pos_x);
    end
  end

  // stage B: squared radius and cross term
  logic [W-1:0]       b_pm_r;
  logic [W-1:0]       b_qm_r;
  logic               b_pn_r;
  logic               b_qn_r;
  logic               b_zero_r;
  logic [SW-1:0]      b_s_r;
  logic signed [SW:0] b_t_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b_pm_r   <= a_pm_r;
      b_qm_r   <= a_qm_r;
      b_pn_r   <= a_pn_r;
      b_qn_r   <= a_qn_r;
      b_zero_r <= a_zero_r;
      b_s_r    <= a_pp_r + a_qq_r;
      b_t_r    <= (SW+1)'(a_xq_r) - (SW+1)'(a_yp_r);
    end
  end

  // stage C: magnitude of the cross term
  logic [W-1:0]  c_pm_r;
  logic [W-1:0]  c_qm_r;
  logic          c_pn_r;
  logic          c_qn_r;
  logic          c_tn_r;
  logic          c_zero_r;
  logic [SW-1:0] c_s_r;
  logic [SW-1:0] c_tm_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_pm_r   <= b_pm_r;
      c_qm_r   <= b_qm_r;
      c_pn_r   <= b_pn_r;
      c_qn_r   <= b_qn_r;
      c_tn_r   <= b_t_r[SW];
      c_zero_r <= b_zero_r;
      c_s_r    <= b_s_r;
      c_tm_r   <= b_t_r[SW] ? SW'(-b_t_r) : SW'(b_t_r);
    end
  end

  // square-root row
  logic [NR+1:0] sq_rem  [0:NR];
  logic [NR-1:0] sq_root [0:NR];
  logic [PW-1:0] sq_pay  [0:NR];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_pay[0]  = {c_zero_r, c_tn_r, c_qn_r, c_pn_r, c_tm_r, c_s_r, c_qm_r, c_pm_r};

  for (genvar i = 0; i < NR; i++) begin : g_sqrt
    localparam int J0 = 2 * (NR - 1 - i);
    logic [1:0] pair;
    if (J0 >= 2 * F) begin : g_pair
      assign pair = sq_pay[i][S_LO + J0 - 2 * F +: 2];
    end else begin : g_low
      assign pair = 2'b00;
    end
    rj_sqrt_cell #(
      .NR (NR),
      .PW (PW)
    ) u_cell (
      .clk    (clk),
      .en     (en),
      .pair_i (pair),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .pay_i  (sq_pay[i]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .pay_o  (sq_pay[i+1])
    );
  end

  // products for the range-rate terms
  logic [DW_T-1:0] den_p;
  logic [W+SW-1:0] nq_p;
  logic [W+SW-1:0] np_p;
  logic [PW-1:0]   m1_pay_r;
  logic [PW-1:0]   m2_pay_r;
  logic [NR-1:0]   m1_rx_r;
  logic [NR-1:0]   m2_rx_r;

  rj_mul #(.AW(SW), .BW(NR)) u_mul_den (
    .clk (clk),
    .en  (en),
    .a_i (sq_pay[NR][S_LO +: SW]),
    .b_i (sq_root[NR]),
    .p_o (den_p)
  );

  rj_mul #(.AW(W), .BW(SW)) u_mul_nq (
    .clk (clk),
    .en  (en),
    .a_i (sq_pay[NR][QM_LO +: W]),
    .b_i (sq_pay[NR][T_LO +: SW]),
    .p_o (nq_p)
  );

  rj_mul #(.AW(W), .BW(SW)) u_mul_np (
    .clk (clk),
    .en  (en),
    .a_i (sq_pay[NR][PM_LO +: W]),
    .b_i (sq_pay[NR][T_LO +: SW]),
    .p_o (np_p)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      m1_pay_r <= sq_pay[NR];
      m2_pay_r <= m1_pay_r;
      m1_rx_r  <= sq_root[NR];
      m2_rx_r  <= m1_rx_r;
    end
  end

  // divider lanes
  logic [K:0]               quo [rj_pkg::NUM_DIV];
  logic [rj_pkg::NUM_DIV-1:0] ovf;
  logic [2*F-1:0]           fz;

  assign fz = '0;

  rj_div_lane #(.NW(NW_R), .DW(NR), .K(K)) u_div_rpx (
    .clk (clk), .en (en),
    .num_i ({m2_pay_r[PM_LO +: W], fz}), .den_i (m2_rx_r),
    .quo_o (quo[rj_pkg::DIV_RPX]), .ovf_o (ovf[rj_pkg::DIV_RPX])
  );

  rj_div_lane #(.NW(NW_R), .DW(NR), .K(K)) u_div_rpy (
    .clk (clk), .en (en),
    .num_i ({m2_pay_r[QM_LO +: W], fz}), .den_i (m2_rx_r),
    .quo_o (quo[rj_pkg::DIV_RPY]), .ovf_o (ovf[rj_pkg::DIV_RPY])
  );

  rj_div_lane #(.NW(NW_R), .DW(SW), .K(K)) u_div_bpx (
    .clk (clk), .en (en),
    .num_i ({m2_pay_r[QM_LO +: W], fz}), .den_i (m2_pay_r[S_LO +: SW]),
    .quo_o (quo[rj_pkg::DIV_BPX]), .ovf_o (ovf[rj_pkg::DIV_BPX])
  );

  rj_div_lane #(.NW(NW_R), .DW(SW), .K(K)) u_div_bpy (
    .clk (clk), .en (en),
    .num_i ({m2_pay_r[PM_LO +: W], fz}), .den_i (m2_pay_r[S_LO +: SW]),
    .quo_o (quo[rj_pkg::DIV_BPY]), .ovf_o (ovf[rj_pkg::DIV_BPY])
  );

  rj_div_lane #(.NW(NW_T), .DW(DW_T), .K(K)) u_div_tpx (
    .clk (clk), .en (en),
    .num_i ({nq_p, fz}), .den_i (den_p),
    .quo_o (quo[rj_pkg::DIV_TPX]), .ovf_o (ovf[rj_pkg::DIV_TPX])
  );

  rj_div_lane #(.NW(NW_T), .DW(DW_T), .K(K)) u_div_tpy (
    .clk (clk), .en (en),
    .num_i ({np_p, fz}), .den_i (den_p),
    .quo_o (quo[rj_pkg::DIV_TPY]), .ovf_o (ovf[rj_pkg::DIV_TPY])
  );

  // signs and zero flag ride alongside the divider lanes
  rj_pkg::rj_side_t side_nxt;
  rj_pkg::rj_side_t side_r [0:K+1];

  always_comb begin
    side_nxt.zero                 = m2_pay_r[ZR_B];
    side_nxt.neg[rj_pkg::DIV_RPX] = m2_pay_r[PN_B];
    side_nxt.neg[rj_pkg::DIV_RPY] = m2_pay_r[QN_B];
    side_nxt.neg[rj_pkg::DIV_BPX] = !m2_pay_r[QN_B];
    side_nxt.neg[rj_pkg::DIV_BPY] = m2_pay_r[PN_B];
    side_nxt.neg[rj_pkg::DIV_TPX] = m2_pay_r[QN_B] ^ m2_pay_r[TN_B];
    side_nxt.neg[rj_pkg::DIV_TPY] = !(m2_pay_r[PN_B] ^ m2_pay_r[TN_B]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int i = 1; i <= K + 1; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // saturation and output register
  logic [W-1:0] res_nxt [rj_pkg::NUM_DIV];
  logic [W-1:0] res_r   [rj_pkg::NUM_DIV];
  logic         zero_r;

  for (genvar d = 0; d < rj_pkg::NUM_DIV; d++) begin : g_sat
    logic [W-1:0] mag;
    assign mag = quo[d][W-1:0];
    always_comb begin
      if (side_r[K+1].zero) begin
        res_nxt[d] = '0;
      end else if (side_r[K+1].neg[d]) begin
        res_nxt[d] = (ovf[d] || quo[d] > HALF) ? W'(HALF) : W'(~mag + 1'b1);
      end else begin
        res_nxt[d] = (ovf[d] || quo[d] > MAXP) ? W'(MAXP) : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < rj_pkg::NUM_DIV; d++) begin
        res_r[d] <= res_nxt[d];
      end
      zero_r <= side_r[K+1].zero;
    end
  end

  assign out_valid         = vld_r[LAT-1];
  assign out_range_by_px   = res_r[rj_pkg::DIV_RPX];
  assign out_range_by_py   = res_r[rj_pkg::DIV_RPY];
  assign out_bearing_by_px = res_r[rj_pkg::DIV_BPX];
  assign out_bearing_by_py = res_r[rj_pkg::DIV_BPY];
  assign out_rate_by_px    = res_r[rj_pkg::DIV_TPX];
  assign out_rate_by_py    = res_r[rj_pkg::DIV_TPY];
  assign out_rate_by_vx    = res_r[rj_pkg::DIV_RPX];
  assign out_rate_by_vy    = res_r[rj_pkg::DIV_RPY];
  assign out_zero_position = zero_r;

  a_zero_entries: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_position |->
      out_range_by_px == '0 && out_range_by_py == '0 &&
      out_bearing_by_px == '0 && out_bearing_by_py == '0 &&
      out_rate_by_px == '0 && out_rate_by_py == '0)
    else $error("zero position with nonzero entries");

  a_rate_copy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rate_by_vx == out_range_by_px && out_rate_by_vy == out_range_by_py)
    else $error("velocity entries differ from range entries");

  a_range_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_position |->
      !(out_range_by_px == '0 && out_range_by_py == '0))
    else $error("range derivatives vanish off the origin");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(vld_r))
    else $error("pipeline moved while the output transaction was stalled");

endmodule

// ===== src/rj_sqrt_cell.sv =====
// One square-root cell: settles one root bit and passes the transaction on.
`timescale 1ns / 1ps
module rj_sqrt_cell #(
  parameter int NR = 48,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [1:0]    pair_i,
  input  logic [NR+1:0] rem_i,
  input  logic [NR-1:0] root_i,
  input  logic [PW-1:0] pay_i,
  output logic [NR+1:0] rem_o,
  output logic [NR-1:0] root_o,
  output logic [PW-1:0] pay_o
);

  logic [NR+1:0] cur;
  logic [NR+1:0] trial;
  logic [NR+1:0] rem_nxt;
  logic          take;
  logic [NR+1:0] rem_r;
  logic [NR-1:0] root_r;
  logic [PW-1:0] pay_r;

  assign cur     = {rem_i[NR-1:0], pair_i};
  assign trial   = {root_i, 2'b01};
  assign take    = cur >= trial;
  assign rem_nxt = take ? cur - trial : cur;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= {root_i[NR-2:0], take};
      pay_r  <= pay_i;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign pay_o  = pay_r;

endmodule

// ===== src/rj_div_cell.sv =====
// One divider cell: settles one quotient bit by restoring subtraction.
`timescale 1ns / 1ps
module rj_div_cell #(
  parameter int DW  = 48,
  parameter int K   = 33,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [K-1:0]  low_i,
  input  logic [K-1:0]  quo_i,
  input  logic          ovf_i,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] den_o,
  output logic [K-1:0]  low_o,
  output logic [K-1:0]  quo_o,
  output logic          ovf_o
);

  logic [DW:0]   cur;
  logic [DW+1:0] diff;
  logic          ge;
  logic [DW-1:0] rem_nxt;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [K-1:0]  low_r;
  logic [K-1:0]  quo_r;
  logic          ovf_r;

  assign cur     = {rem_i, low_i[K-1-IDX]};
  assign diff    = (DW+2)'(cur) - (DW+2)'(den_i);
  assign ge      = !diff[DW+1];
  assign rem_nxt = ge ? diff[DW-1:0] : cur[DW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= den_i;
      low_r <= low_i;
      quo_r <= {quo_i[K-2:0], ge};
      ovf_r <= ovf_i;
    end
  end

  assign rem_o = rem_r;
  assign den_o = den_r;
  assign low_o = low_r;
  assign quo_o = quo_r;
  assign ovf_o = ovf_r;

endmodule

// ===== src/rj_mul.sv =====
// Two-stage multiplier built from four half-width partial products.
`timescale 1ns / 1ps
module rj_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] ll_r;
  logic [AH+BL-1:0] hl_r;
  logic [AL+BH-1:0] lh_r;
  logic [AH+BH-1:0] hh_r;
  logic [PW-1:0]    p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= (AL+BL)'(a_i[AL-1:0]) * (AL+BL)'(b_i[BL-1:0]);
      hl_r <= (AH+BL)'(a_i[AW-1:AL]) * (AH+BL)'(b_i[BL-1:0]);
      lh_r <= (AL+BH)'(a_i[AL-1:0]) * (AL+BH)'(b_i[BW-1:BL]);
      hh_r <= (AH+BH)'(a_i[AW-1:AL]) * (AH+BH)'(b_i[BW-1:BL]);
      p_r  <= (PW'(hh_r) << (AL + BL)) + (PW'(hl_r) << AL) + (PW'(lh_r) << BL)
              + PW'(ll_r);
    end
  end

  assign p_o = p_r;

endmodule

// ===== src/rj_div_lane.sv =====
// Divider lane: overflow check, a row of quotient cells, then rounding.
`timescale 1ns / 1ps
module rj_div_lane #(
  parameter int NW = 64,
  parameter int DW = 48,
  parameter int K  = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [K:0]    quo_o,
  output logic          ovf_o
);

  localparam int HW = NW - K;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [HW-1:0] hi;
  logic          ovf_nxt;
  logic [DW-1:0] rem0_r;
  logic [DW-1:0] den0_r;
  logic [K-1:0]  low0_r;
  logic          ovf0_r;

  logic [DW-1:0] c_rem [0:K];
  logic [DW-1:0] c_den [0:K];
  logic [K-1:0]  c_low [0:K];
  logic [K-1:0]  c_quo [0:K];
  logic          c_ovf [0:K];

  logic          up;
  logic [K:0]    quo_r;
  logic          ovf_r;

  assign hi      = num_i[NW-1:K];
  assign ovf_nxt = CW'(hi) >= CW'(den_i);

  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r <= DW'(hi);
      den0_r <= den_i;
      low0_r <= num_i[K-1:0];
      ovf0_r <= ovf_nxt;
    end
  end

  assign c_rem[0] = rem0_r;
  assign c_den[0] = den0_r;
  assign c_low[0] = low0_r;
  assign c_quo[0] = '0;
  assign c_ovf[0] = ovf0_r;

  for (genvar i = 0; i < K; i++) begin : g_cell
    rj_div_cell #(
      .DW  (DW),
      .K   (K),
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .en    (en),
      .rem_i (c_rem[i]),
      .den_i (c_den[i]),
      .low_i (c_low[i]),
      .quo_i (c_quo[i]),
      .ovf_i (c_ovf[i]),
      .rem_o (c_rem[i+1]),
      .den_o (c_den[i+1]),
      .low_o (c_low[i+1]),
      .quo_o (c_quo[i+1]),
      .ovf_o (c_ovf[i+1])
    );
  end

  // round half away from zero on the magnitude
  assign up = {c_rem[K], 1'b0} >= {1'b0, c_den[K]};

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= (K+1)'(c_quo[K]) + (K+1)'(up);
      ovf_r <= c_ovf[K];
    end
  end

  assign quo_o = quo_r;
  assign ovf_o = ovf_r;

endmodule

// ===== test/radar_jacobian_tb.sv =====
// Self-checking testbench for radar_jacobian: directed and random track states.
`timescale 1ns / 1ps
module radar_jacobian_tb;
  localparam int W = 32;
  localparam int F = 16;
  localparam int WATCHDOG = 5000;

  typedef logic [255:0] wide_t;
  typedef struct {
    logic signed [W-1:0] ent [8];
    logic                zero;
  } jac_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic signed [W-1:0] in_pos_x = 0, in_pos_y = 0, in_vel_x = 0, in_vel_y = 0;
  logic in_stall, out_valid, out_zero_position;
  logic signed [W-1:0] o [8];

  jac_t expected_q[$];
  int errors = 0;
  int idle_in_pct = 0, idle_out_pct = 0;
  int quiet_cycles = 0;
  string ent_name [8] = '{"range_by_px", "range_by_py", "bearing_by_px", "bearing_by_py",
                          "rate_by_px", "rate_by_py", "rate_by_vx", "rate_by_vy"};

  always #5 clk = ~clk;

  radar_jacobian u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_vel_x(in_vel_x), .in_vel_y(in_vel_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_range_by_px(o[0]), .out_range_by_py(o[1]),
    .out_bearing_by_px(o[2]), .out_bearing_by_py(o[3]),
    .out_rate_by_px(o[4]), .out_rate_by_py(o[5]),
    .out_rate_by_vx(o[6]), .out_rate_by_vy(o[7]),
    .out_zero_position(out_zero_position)
  );

  // round half away from zero, then saturate to the word range
  function automatic logic [W-1:0] rounded_entry(wide_t mag, logic neg, wide_t den);
    wide_t n, q, r;
    n = mag << (2 * F);
    q = n / den;
    r = n % den;
    if ((r << 1) >= den) q = q + 1;
    if (neg && q != 0) begin
      if (q > (wide_t'(1) << (W - 1))) return {1'b1, {(W-1){1'b0}}};
      return W'(-q);
    end
    if (q > ((wide_t'(1) << (W - 1)) - 1)) return {1'b0, {(W-1){1'b1}}};
    return W'(q);
  endfunction

  function automatic jac_t jacobian_of(logic signed [W-1:0] px, logic signed [W-1:0] py,
                                       logic signed [W-1:0] vx, logic signed [W-1:0] vy);
    jac_t j;
    wide_t pm, qm, s, sh, rx, c, tm, den;
    logic signed [129:0] t;
    logic pn, qn, tn;
    j.zero = 0;
    for (int i = 0; i < 8; i++) j.ent[i] = 0;
    if (px == 0 && py == 0) begin
      j.zero = 1;
      return j;
    end
    pn = px[W-1];
    qn = py[W-1];
    pm = pn ? wide_t'(-64'(px)) : wide_t'(px);
    qm = qn ? wide_t'(-64'(py)) : wide_t'(py);
    s = pm * pm + qm * qm;
    sh = s << (2 * F);
    rx = 0;
    for (int b = 63; b >= 0; b--) begin
      c = rx | (wide_t'(1) << b);
      if (c * c <= sh) rx = c;
    end
    j.ent[0] = rounded_entry(pm, pn, rx);
    j.ent[1] = rounded_entry(qm, qn, rx);
    j.ent[2] = rounded_entry(qm, !qn, s);
    j.ent[3] = rounded_entry(pm, pn, s);
    t = 130'(vx) * 130'(py) - 130'(vy) * 130'(px);
    tn = t < 0;
    tm = tn ? wide_t'(-t) : wide_t'(t);
    den = s * rx;
    j.ent[4] = rounded_entry(qm * tm, qn != tn, den);
    j.ent[5] = rounded_entry(pm * tm, pn == tn, den);
    j.ent[6] = j.ent[0];
    j.ent[7] = j.ent[1];
    return j;
  endfunction

  task automatic send_state(logic signed [W-1:0] px, logic signed [W-1:0] py,
                            logic signed [W-1:0] vx, logic signed [W-1:0] vy);
    in_valid <= 1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_vel_x <= vx;
    in_vel_y <= vy;
    do @(posedge clk); while (in_stall);
    expected_q = {expected_q, jacobian_of(px, py, vx, vy)};
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  // result checking, receiver stall and watchdog
  always @(posedge clk) begin
    jac_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("DONE: errors detected");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected transaction");
          errors++;
        end else begin
          e = expected_q.pop_front();
          for (int i = 0; i < 8; i++)
            if (o[i] !== e.ent[i]) begin
              $error("%s expected %0d actual %0d", ent_name[i], e.ent[i], o[i]);
              errors++;
            end
          if (out_zero_position !== e.zero) begin
            $error("zero_position expected %0d actual %0d", e.zero, out_zero_position);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < idle_out_pct);
    end
  end

  function automatic logic signed [W-1:0] pick_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return $signed($urandom_range(0, 64)) - 32;
      3: return {$urandom_range(1) ? 2'b10 : 2'b01, 30'($urandom)};
      default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  task automatic test_zero_position();
    send_state(0, 0, 0, 0);
    send_state(0, 0, 32'sh7fff_ffff, 32'sh8000_0000);
    send_state(0, 0, $urandom, $urandom);
  endtask

  task automatic test_extremes();
    logic signed [W-1:0] mx = 32'sh7fff_ffff, mn = 32'sh8000_0000;
    send_state(mx, mx, mx, mn);
    send_state(mn, mn, mn, mx);
    send_state(mx, mn, mn, mn);
    send_state(mn, mx, mx, mx);
    send_state(1, 0, mx, mx);
    send_state(0, 1, mn, mx);
    send_state(-1, 0, mn, mn);
    send_state(0, -1, mx, mn);
    send_state(1, 1, mn, mx);
    send_state(mn, 0, 0, 0);
    send_state(0, mn, 32'sh0001_0000, 0);
    send_state(32'sh0003_0000, 32'sh0004_0000, 32'sh0001_0000, -32'sh0002_0000);
    send_state(-32'sh0003_0000, 32'sh0004_0000, 0, 0);
    send_state(32'sh0000_8000, -32'sh0000_8000, 32'sh0010_0000, 32'sh0010_0000);
    send_state(32'sh7fff_ffff, 1, 1, mx);
  endtask

  task automatic test_random(int n, int in_pct, int out_pct);
    logic signed [W-1:0] px, py;
    idle_in_pct = in_pct;
    idle_out_pct = out_pct;
    for (int k = 0; k < n; k++) begin
      px = pick_word();
      py = pick_word();
      case ($urandom_range(19))
        0: px = 0;
        1: py = 0;
        2: begin px = 0; py = 0; end
        default: ;
      endcase
      send_state(px, py, pick_word(), pick_word());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    idle_in_pct = 36;
    idle_out_pct = 53;
    test_zero_position();
    test_extremes();
    test_random(300, 36, 53);
    test_random(300, 53, 36);
    test_random(300, 0, 0);
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== files.f =====
src/rj_pkg.sv
src/rj_sqrt_cell.sv
src/rj_div_cell.sv
src/rj_mul.sv
src/rj_div_lane.sv
src/radar_jacobian.sv
test/radar_jacobian_tb.sv
